### sv/dtos_pkg.sv
// shared types and constants for the draw task overlap scoreboard
`default_nettype none
package dtos_pkg;
    localparam int TableDepth = 16;
    localparam int PosW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int CoordW = 15;
    localparam int DimW = 14;
    localparam int UnitW = 8;
    localparam int QDepth = 2;

    typedef enum logic [1:0] {ACT_ADD = 2'd0, ACT_SET = 2'd1, ACT_PURGE = 2'd2, ACT_FIND = 2'd3} action_t;
    typedef enum logic [1:0] {ST_QUEUED = 2'd0, ST_BUSY = 2'd1, ST_WAIT = 2'd2, ST_READY = 2'd3} tstate_t;
    typedef enum logic [1:0] {RS_OK = 2'd0, RS_FULL = 2'd1, RS_NONE = 2'd2, RS_BADPOS = 2'd3} rstatus_t;
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] left;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] right;
        logic signed [CoordW-1:0] bottom;
    } rect_t;

    typedef struct packed {
        action_t          action;
        rect_t            rect;
        logic [UnitW-1:0] unit_id;
        logic [PosW-1:0]  position;
        logic             use_start;
        tstate_t          new_state;
    } req_t;

    typedef struct packed {
        rstatus_t        status;
        logic [PosW-1:0] found_position;
        logic [CntW-1:0] task_count;
    } rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_PURGE, BK_SCAN, BK_CHECK, BK_DONE
    } bk_state_t;

    function automatic logic overlap(rect_t a, rect_t b);
        logic signed [CoordW-1:0] l, t, r, bt;
        l  = (a.left > b.left) ? a.left : b.left;
        t  = (a.top > b.top) ? a.top : b.top;
        r  = (a.right < b.right) ? a.right : b.right;
        bt = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        return (l <= r) && (t <= bt);
    endfunction
endpackage
`default_nettype wire

### sv/dtos_front.sv
// request queue between the input port and the table engine
`default_nettype none
module dtos_front import dtos_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_push,
    input  wire req_t in_req,
    output logic      in_full,
    output logic      out_valid,
    output req_t      out_req,
    input  wire logic out_take
);
    localparam int QW = $clog2(QDepth);
    req_t mem_reg [QDepth];
    logic [QW-1:0] wr_reg, rd_reg;
    logic [QW:0] cnt_reg;

    assign in_full = (cnt_reg == (QW+1)'(QDepth));
    assign out_valid = (cnt_reg != '0);
    assign out_req = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (in_push && !in_full)
            mem_reg[wr_reg] <= in_req;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (in_push && !in_full)
                wr_reg <= (wr_reg == QW'(QDepth-1)) ? '0 : wr_reg + 1'b1;
            if (out_take && out_valid)
                rd_reg <= (rd_reg == QW'(QDepth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QW+1)'(in_push && !in_full)
                               - (QW+1)'(out_take && out_valid);
        end
    end
endmodule
`default_nettype wire

### sv/dtos_back.sv
// task table and sequencer for add, set state, purge and find
`default_nettype none
module dtos_back import dtos_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire req_t req,
    output logic      req_take,
    input  wire logic [DimW-1:0] scr_w,
    input  wire logic [DimW-1:0] scr_h,
    output logic      rsp_valid,
    output rsp_t      rsp,
    input  wire logic rsp_pop
);
    rect_t            rect_reg [TableDepth];
    tstate_t          st_reg   [TableDepth];
    logic [UnitW-1:0] unit_reg [TableDepth];
    logic [CntW-1:0]  cnt_reg, cnt_next;
    bk_state_t        bk_reg, bk_next;
    req_t             cur_reg, cur_next;
    logic [CntW-1:0]  i_reg, i_next, j_reg, j_next, w_reg, w_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg, out_next;
    logic             ov_reg, ov_next;
    logic             wr_add, wr_set, wr_move;
    logic [PosW-1:0]  ip, jp;
    logic             head_block, cand_ok, blocker;

    assign ip = i_reg[PosW-1:0];
    assign jp = j_reg[PosW-1:0];
    assign rsp_valid = ov_reg;
    assign rsp = out_reg;

    // full-screen head check
    always_comb
    begin
        head_block = (cnt_reg != '0) && (st_reg[0] != ST_QUEUED)
            && (rect_reg[0].left <= 0) && (rect_reg[0].top <= 0)
            && (16'(signed'(rect_reg[0].right)) >= $signed({2'b00, scr_w}) - 16'sd1)
            && (16'(signed'(rect_reg[0].bottom)) >= $signed({2'b00, scr_h}) - 16'sd1);
        cand_ok = (st_reg[ip] == ST_QUEUED)
            && (unit_reg[ip] == '0 || unit_reg[ip] == cur_reg.unit_id);
        blocker = (st_reg[jp] != ST_READY) && overlap(rect_reg[jp], rect_reg[ip]);
    end

    // sequencer
    always_comb
    begin
        bk_next = bk_reg;
        cur_next = cur_reg;
        i_next = i_reg;
        j_next = j_reg;
        w_next = w_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        out_next = out_reg;
        ov_next = ov_reg && !rsp_pop;
        req_take = 1'b0;
        wr_add = 1'b0;
        wr_set = 1'b0;
        wr_move = 1'b0;
        unique case (bk_reg)
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    req_take = 1'b1;
                    cur_next = req;
                    res_next = '{RS_OK, '0, cnt_reg};
                    unique case (req.action)
                        ACT_ADD:
                        begin
                            if (cnt_reg == CntW'(TableDepth))
                                res_next.status = RS_FULL;
                            else
                            begin
                                wr_add = 1'b1;
                                res_next.found_position = cnt_reg[PosW-1:0];
                                cnt_next = cnt_reg + 1'b1;
                                res_next.task_count = cnt_next;
                            end
                            bk_next = BK_DONE;
                        end
                        ACT_SET:
                        begin
                            if (CntW'(req.position) < cnt_reg)
                            begin
                                wr_set = 1'b1;
                                res_next.found_position = req.position;
                            end
                            else
                                res_next.status = RS_BADPOS;
                            bk_next = BK_DONE;
                        end
                        ACT_PURGE:
                        begin
                            i_next = '0;
                            w_next = '0;
                            bk_next = BK_PURGE;
                        end
                        default:
                        begin
                            if (req.use_start && CntW'(req.position) >= cnt_reg)
                            begin
                                res_next.status = RS_BADPOS;
                                bk_next = BK_DONE;
                            end
                            else
                            begin
                                res_next.status = RS_NONE;
                                i_next = req.use_start ? CntW'(req.position) + 1'b1 : '0;
                                bk_next = head_block ? BK_DONE : BK_SCAN;
                            end
                        end
                    endcase
                end
            end
            BK_PURGE:
            begin
                if (i_reg == cnt_reg)
                begin
                    cnt_next = w_reg;
                    res_next.task_count = w_reg;
                    bk_next = BK_DONE;
                end
                else
                begin
                    if (st_reg[ip] != ST_READY)
                    begin
                        wr_move = 1'b1;
                        w_next = w_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            BK_SCAN:
            begin
                if (i_reg >= cnt_reg)
                    bk_next = BK_DONE;
                else if (cand_ok)
                begin
                    j_next = '0;
                    bk_next = BK_CHECK;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            BK_CHECK:
            begin
                if (j_reg == i_reg)
                begin
                    res_next.status = RS_OK;
                    res_next.found_position = ip;
                    bk_next = BK_DONE;
                end
                else if (blocker)
                begin
                    i_next = i_reg + 1'b1;
                    bk_next = BK_SCAN;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            BK_DONE:
            begin
                if (!ov_reg || rsp_pop)
                begin
                    ov_next = 1'b1;
                    out_next = res_reg;
                    bk_next = BK_IDLE;
                end
            end
            default: bk_next = BK_IDLE;
        endcase
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            rect_reg[cnt_reg[PosW-1:0]] <= req.rect;
            st_reg[cnt_reg[PosW-1:0]] <= ST_QUEUED;
            unit_reg[cnt_reg[PosW-1:0]] <= req.unit_id;
        end
        if (wr_set)
            st_reg[req.position] <= req.new_state;
        if (wr_move)
        begin
            rect_reg[w_reg[PosW-1:0]] <= rect_reg[ip];
            st_reg[w_reg[PosW-1:0]] <= st_reg[ip];
            unit_reg[w_reg[PosW-1:0]] <= unit_reg[ip];
        end
        cur_reg <= cur_next;
        i_reg <= i_next;
        j_reg <= j_next;
        w_reg <= w_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_reg <= BK_IDLE;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            bk_reg <= bk_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

### sv/draw_task_overlap_scoreboard.sv
// top level of the draw task overlap scoreboard
//
// input channel: push/full; a request is taken when push is high and full low.
// requests sit in a two-entry queue, then the table engine runs them one at
// a time. result channel: empty/pop; the result shows while empty is low and
// leaves on pop. config: cfg_valid/cfg_ready with cfg_index (0 width,
// 1 height) and cfg_data; ready is always high.
// purge walks the whole table; find scans for a queued candidate of a matching
// unit and checks it against older entries (one entry compare per cycle in the
// overlap check loop). the next request starts only after the previous result
// is in the output register, so the engine takes no new request before it is
// through with the last one.
// reset empties the table and restores 480x320. a stalled result holds the
// engine in its done state; the input queue keeps filling until full.
`default_nettype none
module draw_task_overlap_scoreboard import dtos_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire logic [1:0] action,
    input  wire logic signed [CoordW-1:0] left,
    input  wire logic signed [CoordW-1:0] top,
    input  wire logic signed [CoordW-1:0] right,
    input  wire logic signed [CoordW-1:0] bottom,
    input  wire logic [UnitW-1:0] unit_id,
    input  wire logic [PosW-1:0] position,
    input  wire logic use_start,
    input  wire logic [1:0] new_state,
    output logic      empty,
    input  wire logic pop,
    output logic [1:0] status,
    output logic [PosW-1:0] found_position,
    output logic [CntW-1:0] task_count,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [DimW-1:0] cfg_data
);
    req_t in_req, q_req;
    rsp_t rsp;
    logic q_valid, q_take, rsp_valid;
    logic [DimW-1:0] scr_w_reg, scr_h_reg;

    assign in_req = '{action_t'(action), '{left, top, right, bottom}, unit_id,
                      position, use_start, tstate_t'(new_state)};
    assign cfg_ready = 1'b1;

    // screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= DimW'(480);
            scr_h_reg <= DimW'(320);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH)
                scr_w_reg <= cfg_data;
            else
                scr_h_reg <= cfg_data;
        end
    end

    dtos_front u_front (
        .clk(clk), .rst_n(rst_n), .in_push(push), .in_req(in_req), .in_full(full),
        .out_valid(q_valid), .out_req(q_req), .out_take(q_take)
    );

    dtos_back u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(q_valid), .req(q_req), .req_take(q_take),
        .scr_w(scr_w_reg), .scr_h(scr_h_reg), .rsp_valid(rsp_valid), .rsp(rsp),
        .rsp_pop(pop)
    );

    assign empty = !rsp_valid;
    assign status = rsp.status;
    assign found_position = rsp.found_position;
    assign task_count = rsp.task_count;
endmodule
`default_nettype wire

### sv/dtos_checker.sv
// port-level checks for the scoreboard, bound to the top level
`default_nettype none
module dtos_checker import dtos_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic empty,
    input wire logic pop,
    input wire logic [1:0] status,
    input wire logic [PosW-1:0] found_position,
    input wire logic [CntW-1:0] task_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        empty == 1'b0 && !pop |=> !empty && $stable(status) && $stable(task_count))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> task_count <= CntW'(TableDepth))
        else $error("task count out of range");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == RS_FULL |-> task_count == CntW'(TableDepth) && found_position == '0)
        else $error("full flagged on non-full table");
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (status == RS_BADPOS || status == RS_NONE) |-> found_position == '0)
        else $error("position on failed request");
endmodule

bind draw_task_overlap_scoreboard dtos_checker u_dtos_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .status(status),
    .found_position(found_position), .task_count(task_count)
);
`default_nettype wire

### tb/draw_task_overlap_scoreboard_test.sv
// self-checking testbench for the draw task overlap scoreboard
`default_nettype none

module draw_task_overlap_scoreboard_test;
    import dtos_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // expected result of one request
    typedef struct packed {
        rstatus_t        status;
        logic [PosW-1:0] found_position;
        logic [CntW-1:0] task_count;
    } outcome_t;

    // table predictor and store of expected outcomes
    class task_table_checker;
        rect_t            rects[TableDepth];
        tstate_t          states[TableDepth];
        logic [UnitW-1:0] units[TableDepth];
        int               count;
        int               width_px;
        int               height_px;
        outcome_t         pending[$];
        int               errors;

        function void clear_table();
            count = 0;
            width_px = 480;
            height_px = 320;
            pending.delete();
            errors = 0;
        endfunction

        function void set_register(logic idx, logic [DimW-1:0] val);
            if (idx == CFG_WIDTH)
                width_px = val;
            else
                height_px = val;
        endfunction

        function bit rects_touch(rect_t a, rect_t b);
            int l, t, r, bt;
            l  = (a.left > b.left) ? a.left : b.left;
            t  = (a.top > b.top) ? a.top : b.top;
            r  = (a.right < b.right) ? a.right : b.right;
            bt = (a.bottom < b.bottom) ? a.bottom : b.bottom;
            return (l <= r) && (t <= bt);
        endfunction

        function bit free_of_older(int idx);
            for (int j = 0; j < idx; j++)
                if (states[j] != ST_READY && rects_touch(rects[j], rects[idx]))
                    return 0;
            return 1;
        endfunction

        // predict the outcome of an accepted request
        function void note_request(req_t rq);
            outcome_t o;
            int w;
            bit blocked;
            o.status = RS_OK;
            o.found_position = '0;
            case (rq.action)
                ACT_ADD:
                begin
                    if (count >= TableDepth)
                        o.status = RS_FULL;
                    else
                    begin
                        rects[count] = rq.rect;
                        states[count] = ST_QUEUED;
                        units[count] = rq.unit_id;
                        o.found_position = count;
                        count++;
                    end
                end
                ACT_SET:
                begin
                    if (rq.position < count)
                    begin
                        states[rq.position] = rq.new_state;
                        o.found_position = rq.position;
                    end
                    else
                        o.status = RS_BADPOS;
                end
                ACT_PURGE:
                begin
                    w = 0;
                    for (int i = 0; i < count; i++)
                        if (states[i] != ST_READY)
                        begin
                            rects[w] = rects[i];
                            states[w] = states[i];
                            units[w] = units[i];
                            w++;
                        end
                    count = w;
                end
                default:
                begin
                    if (rq.use_start && rq.position >= count)
                        o.status = RS_BADPOS;
                    else
                    begin
                        o.status = RS_NONE;
                        blocked = count > 0 && states[0] != ST_QUEUED
                            && int'(rects[0].left) <= 0 && int'(rects[0].top) <= 0
                            && int'(rects[0].right) >= width_px - 1
                            && int'(rects[0].bottom) >= height_px - 1;
                        if (!blocked)
                            for (int i = rq.use_start ? rq.position + 1 : 0; i < count; i++)
                                if (states[i] == ST_QUEUED
                                    && (units[i] == 0 || units[i] == rq.unit_id)
                                    && free_of_older(i))
                                begin
                                    o.status = RS_OK;
                                    o.found_position = i;
                                    break;
                                end
                    end
                end
            endcase
            o.task_count = count;
            pending.push_back(o);
        endfunction

        // compare a popped result with the oldest expectation
        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
            begin
                $display("%0t status expected %0d actual %0d", $realtime,
                    want.status, got.status);
                errors++;
            end
            if (got.found_position != want.found_position)
            begin
                $display("%0t found_position expected %0d actual %0d", $realtime,
                    want.found_position, got.found_position);
                errors++;
            end
            if (got.task_count != want.task_count)
            begin
                $display("%0t task_count expected %0d actual %0d", $realtime,
                    want.task_count, got.task_count);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic full;
    logic [1:0] action = '0;
    logic signed [CoordW-1:0] left = '0, top = '0, right = '0, bottom = '0;
    logic [UnitW-1:0] unit_id = '0;
    logic [PosW-1:0] position = '0;
    logic use_start = 0;
    logic [1:0] new_state = '0;
    logic empty;
    logic pop = 0;
    logic [1:0] status;
    logic [PosW-1:0] found_position;
    logic [CntW-1:0] task_count;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic cfg_index = 0;
    logic [DimW-1:0] cfg_data = '0;

    task_table_checker tracker = new();
    bit sending_done = 0;
    int unsigned live_entries = 0;

    draw_task_overlap_scoreboard dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .left(left), .top(top), .right(right), .bottom(bottom), .unit_id(unit_id),
        .position(position), .use_start(use_start), .new_state(new_state),
        .empty(empty), .pop(pop), .status(status), .found_position(found_position),
        .task_count(task_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one request and wait for its acceptance; push stays high when no gap follows
    task automatic send_request(req_t rq);
        int gap;
        action <= rq.action;
        left <= rq.rect.left;
        top <= rq.rect.top;
        right <= rq.rect.right;
        bottom <= rq.rect.bottom;
        unit_id <= rq.unit_id;
        position <= rq.position;
        use_start <= rq.use_start;
        new_state <= rq.new_state;
        push <= 1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_request(rq);
        if (rq.action == ACT_ADD && live_entries < TableDepth)
            live_entries++;
        gap = gap_length();
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic write_register(logic idx, logic [DimW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_register(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // wait until every expected result has come, then let the engine settle
    task automatic drain_results();
        push <= 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
    endtask

    function automatic req_t make_rect_req(action_t a, int l, int t, int r, int b,
                                           int u);
        req_t rq;
        rq = '0;
        rq.action = a;
        rq.rect.left = l;
        rq.rect.top = t;
        rq.rect.right = r;
        rq.rect.bottom = b;
        rq.unit_id = u;
        return rq;
    endfunction

    function automatic req_t make_ctl_req(action_t a, int p, bit us, tstate_t s, int u);
        req_t rq;
        rq = '0;
        rq.action = a;
        rq.position = p;
        rq.use_start = us;
        rq.new_state = s;
        rq.unit_id = u;
        return rq;
    endfunction

    // random coordinate, mostly small with occasional extremes
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return -16384;
        if (r == 1)
            return 16383;
        if (r < 4)
            return $signed(15'($urandom));
        return $urandom_range(0, 60) - 10;
    endfunction

    function automatic req_t random_request();
        req_t rq;
        int r, l, t;
        rq = '0;
        rq.unit_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        rq.position = (live_entries > 0 && $urandom_range(0, 9) != 0)
            ? 4'($urandom_range(0, live_entries - 1)) : 4'($urandom);
        rq.use_start = $urandom_range(0, 1);
        rq.new_state = tstate_t'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            rq.action = ACT_ADD;
            l = rand_coord();
            t = rand_coord();
            rq.rect.left = l;
            rq.rect.top = t;
            if ($urandom_range(0, 7) == 0)
            begin
                rq.rect.right = rand_coord();
                rq.rect.bottom = rand_coord();
            end
            else
            begin
                rq.rect.right = l + $urandom_range(0, 25);
                rq.rect.bottom = t + $urandom_range(0, 25);
            end
        end
        else if (r < 65)
            rq.action = ACT_SET;
        else if (r < 75)
            rq.action = ACT_PURGE;
        else
            rq.action = ACT_FIND;
        return rq;
    endfunction

    // result side: random pop stalls, sample at the edge
    initial
    begin
        int hold;
        wait (rst_n);
        forever
        begin
            hold = gap_length();
            if (hold > 0)
            begin
                pop <= 0;
                repeat (hold)
                    @(posedge clk);
            end
            pop <= 1;
            @(posedge clk);
            if (!empty)
                tracker.check_result({rstatus_t'(status), found_position, task_count});
        end
    end

    // stimulus
    initial
    begin
        tracker.clear_table();
        repeat (5)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: full-screen head at reset size, overlap blocking, unit match
        send_request(make_ctl_req(ACT_FIND, 0, 0, ST_QUEUED, 0));
        send_request(make_ctl_req(ACT_SET, 0, 0, ST_BUSY, 0));
        send_request(make_rect_req(ACT_ADD, -16384, -16384, 16383, 16383, 0));
        send_request(make_rect_req(ACT_ADD, 0, 0, 479, 319, 255));
        send_request(make_rect_req(ACT_ADD, 500, 500, 400, 600, 7));
        send_request(make_ctl_req(ACT_FIND, 0, 0, ST_QUEUED, 7));
        send_request(make_ctl_req(ACT_SET, 0, 0, ST_BUSY, 0));
        send_request(make_ctl_req(ACT_FIND, 0, 0, ST_QUEUED, 7));
        send_request(make_ctl_req(ACT_SET, 0, 0, ST_WAIT, 0));
        send_request(make_ctl_req(ACT_FIND, 0, 1, ST_QUEUED, 255));
        send_request(make_ctl_req(ACT_FIND, 2, 1, ST_QUEUED, 7));
        send_request(make_ctl_req(ACT_FIND, 15, 1, ST_QUEUED, 7));
        send_request(make_ctl_req(ACT_SET, 15, 0, ST_READY, 0));
        send_request(make_ctl_req(ACT_SET, 0, 0, ST_READY, 0));
        send_request(make_ctl_req(ACT_FIND, 0, 0, ST_QUEUED, 255));
        send_request(make_ctl_req(ACT_PURGE, 0, 0, ST_QUEUED, 0));
        for (int i = 0; i < 15; i++)
            send_request(make_rect_req(ACT_ADD, i, i, i + 1, i + 1, i));
        send_request(make_rect_req(ACT_ADD, 1, 1, 1, 1, 1));
        send_request(make_ctl_req(ACT_FIND, 14, 0, ST_QUEUED, 3));
        live_entries = 16;

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph)
                0: begin write_register(CFG_WIDTH, 1); write_register(CFG_HEIGHT, 1); end
                1: begin write_register(CFG_WIDTH, 16383); write_register(CFG_HEIGHT, 16383); end
                2: begin write_register(CFG_WIDTH, 20); write_register(CFG_HEIGHT, 30); end
                3: begin write_register(CFG_WIDTH, 8191); write_register(CFG_HEIGHT, 5462); end
                4: begin write_register(CFG_WIDTH, $urandom_range(1, 60));
                         write_register(CFG_HEIGHT, $urandom_range(1, 60)); end
                default: begin write_register(CFG_WIDTH, 480); write_register(CFG_HEIGHT, 320); end
            endcase
            for (int n = 0; n < 150; n++)
            begin
                req_t rq;
                rq = random_request();
                if (rq.action == ACT_PURGE)
                    live_entries = 0;
                // a full-screen head task now and then
                if (rq.action == ACT_ADD && live_entries == 0 && $urandom_range(0, 2) == 0)
                begin
                    rq.rect.left = -$urandom_range(0, 3);
                    rq.rect.top = -$urandom_range(0, 3);
                    rq.rect.right = tracker.width_px - 1 + $urandom_range(0, 1);
                    rq.rect.bottom = tracker.height_px - 1 + $urandom_range(0, 1);
                end
                send_request(rq);
                if (rq.action == ACT_PURGE)
                    live_entries = tracker.count;
            end
        end

        drain_results();
        sending_done = 1;
    end

    // end of run
    initial
    begin
        wait (sending_done);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
